>>> sv/pfc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helpers of the digram cipher unit.
// ---------------------------------------------------------------------------
package pfc_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int CELL_COUNT = SQUARE_SIDE * SQUARE_SIDE;
   localparam int LETTER_W = 5;
   localparam int CELL_IDX_W = $clog2(CELL_COUNT + 1);
   localparam int RC_W = $clog2(SQUARE_SIDE);
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_W = $clog2(MAX_RESULTS);
   localparam int COUNT_W = $clog2(MAX_RESULTS + 1);
   localparam int PFC_QUEUE_DEPTH = 2;
   localparam int CSR_DATA_W = 60;
   localparam int CSR_INDEX_W = 2;
   localparam int LOW_CELLS = 12;
   localparam int MID_CELLS = 12;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DECRYPT_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_LOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_MID = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_LAST = 2'd3;

   localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
   localparam logic [CELL_IDX_W-1:0] CELL_MISSING = CELL_IDX_W'(CELL_COUNT);

   typedef logic [CELL_COUNT-1:0][LETTER_W-1:0] cells_type;

   // one pairing command from the front to the back
   typedef struct packed {
      logic has_pair;
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic last;
   } cmd_type;

   // row of a cell index (small table over the square)
   function automatic logic [RC_W-1:0] cell_row(input logic [CELL_IDX_W-1:0] idx);
      logic [RC_W-1:0] r;
      r = '0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (idx == CELL_IDX_W'(i)) r = RC_W'(i / SQUARE_SIDE);
      end
      return r;
   endfunction

   // column of a cell index
   function automatic logic [RC_W-1:0] cell_col(input logic [CELL_IDX_W-1:0] idx);
      logic [RC_W-1:0] c;
      c = '0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (idx == CELL_IDX_W'(i)) c = RC_W'(i % SQUARE_SIDE);
      end
      return c;
   endfunction

   // wrapping move by one, down when decrypting
   function automatic logic [RC_W-1:0] step_rc(input logic [RC_W-1:0] v, input logic dec);
      logic [RC_W-1:0] r;
      if (dec) r = (v == '0) ? RC_W'(SQUARE_SIDE - 1) : v - RC_W'(1);
      else r = (v == RC_W'(SQUARE_SIDE - 1)) ? '0 : v + RC_W'(1);
      return r;
   endfunction

endpackage

>>> sv/pfc_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_req_if
// Letter input channel: valid/ready with letter and end-of-message flag.
// ---------------------------------------------------------------------------
interface pfc_req_if;
   logic valid;
   logic ready;
   logic [4:0] letter_in;
   logic end_of_message;

   modport source(output valid, output letter_in, output end_of_message, input ready);
   modport sink(input valid, input letter_in, input end_of_message, output ready);
endinterface

>>> sv/pfc_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_rsp_if
// Result channel: valid/ready with letter, run-last and error flags.
// ---------------------------------------------------------------------------
interface pfc_rsp_if;
   logic valid;
   logic ready;
   logic [4:0] letter_out;
   logic run_last;
   logic bad_input;

   modport source(output valid, output letter_out, output run_last, output bad_input,
                  input ready);
   modport sink(input valid, input letter_out, input run_last, input bad_input,
                output ready);
endinterface

>>> sv/pfc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_front
// Pairs incoming letters into digrams and issues commands to the queue.
// ---------------------------------------------------------------------------
module pfc_front (
   input  logic clock,
   input  logic reset,
   input  logic decrypt_mode,
   pfc_req_if.sink req,
   output logic push_valid,
   input  logic push_ready,
   output pfc_pkg::cmd_type push_cmd
);
   import pfc_pkg::*;

   logic holding_ff, holding_in;
   logic [LETTER_W-1:0] first_ff, first_in;
   logic accept;

   assign req.ready = push_ready;
   assign accept = req.valid && push_ready;

   // pairing decision for the arriving letter
   always_comb begin
      holding_in = holding_ff;
      first_in = first_ff;
      push_cmd.has_pair = 1'b0;
      push_cmd.first = first_ff;
      push_cmd.second = req.letter_in;
      push_cmd.last = req.end_of_message;
      if (!holding_ff) begin
         if (!req.end_of_message) begin
            first_in = req.letter_in;
            holding_in = 1'b1;
         end
      end else if (!decrypt_mode && first_ff == req.letter_in) begin
         // doubled letter: pair with filler, keep the letter held
         push_cmd.has_pair = 1'b1;
         push_cmd.second = LETTER_X;
      end else begin
         push_cmd.has_pair = 1'b1;
         holding_in = 1'b0;
      end
      if (req.end_of_message) begin
         holding_in = 1'b0;
         first_in = '0;
      end
   end

   // words that pair nothing and end nothing are absorbed here
   assign push_valid = req.valid && (push_cmd.has_pair || req.end_of_message);

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff <= 1'b0;
         first_ff <= '0;
      end else if (accept) begin
         holding_ff <= holding_in;
         first_ff <= first_in;
      end
   end

endmodule

>>> sv/pfc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_queue
// Small command queue between front and back.
// ---------------------------------------------------------------------------
module pfc_queue #(
   parameter int DEPTH = pfc_pkg::PFC_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  pfc_pkg::cmd_type push_cmd,
   output logic pop_valid,
   input  logic pop_ready,
   output pfc_pkg::cmd_type pop_cmd
);
   import pfc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

>>> sv/pfc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_back
// Looks up digram cells, applies the square rules, tracks the withheld
// filler pair and streams the results one word per cycle while rsp ready is high.
// ---------------------------------------------------------------------------
module pfc_back (
   input  logic clock,
   input  logic reset,
   input  logic decrypt_mode,
   input  pfc_pkg::cells_type cells,
   input  logic pop_valid,
   output logic pop_ready,
   input  pfc_pkg::cmd_type pop_cmd,
   pfc_rsp_if.source rsp
);
   import pfc_pkg::*;

   // first cell holding the letter, or the missing code
   function automatic logic [CELL_IDX_W-1:0] find_cell(input cells_type sq,
                                                       input logic [LETTER_W-1:0] letter);
      logic [CELL_IDX_W-1:0] idx;
      idx = CELL_MISSING;
      for (int i = CELL_COUNT - 1; i >= 0; i--) begin
         if (sq[i] == letter) idx = CELL_IDX_W'(i);
      end
      return idx;
   endfunction

   // lookup stage
   logic lk_valid_ff, lk_valid_in;
   logic [CELL_IDX_W-1:0] lk_a_ff, lk_b_ff;
   logic lk_has_pair_ff, lk_last_ff;
   logic lk_advance;

   // withheld pair state
   logic pend_ff, pend_in;
   logic [LETTER_W-1:0] held_ff, held_in;

   // result list
   logic [LETTER_W-1:0] list_letter_ff [MAX_RESULTS];
   logic list_bad_ff [MAX_RESULTS];
   logic [COUNT_W-1:0] list_cnt_ff;
   logic [SLOT_W-1:0] list_idx_ff;
   logic list_busy_ff;
   logic list_done, can_load;

   // square rule results
   logic [RC_W-1:0] ra, ca, rb, cb, ra_n, ca_n, rb_n, cb_n;
   logic [CELL_IDX_W-1:0] pos1, pos2;
   logic [LETTER_W-1:0] p1, p2;
   logic pair_bad;
   logic [LETTER_W-1:0] ent_letter [MAX_RESULTS];
   logic ent_bad [MAX_RESULTS];
   logic [COUNT_W-1:0] n;

   assign list_done = list_busy_ff && rsp.ready
                      && ({1'b0, list_idx_ff} == list_cnt_ff - COUNT_W'(1));
   assign can_load = !list_busy_ff || list_done;
   assign lk_advance = lk_valid_ff && can_load;
   assign pop_ready = !lk_valid_ff || lk_advance;

   always_comb begin
      lk_valid_in = lk_valid_ff;
      if (pop_valid && pop_ready) lk_valid_in = 1'b1;
      else if (lk_advance) lk_valid_in = 1'b0;
   end

   // lookup registers
   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         lk_a_ff <= find_cell(cells, pop_cmd.first);
         lk_b_ff <= find_cell(cells, pop_cmd.second);
         lk_has_pair_ff <= pop_cmd.has_pair;
         lk_last_ff <= pop_cmd.last;
      end
   end

   // row/column rule and cell fetch
   always_comb begin
      ra = cell_row(lk_a_ff);
      ca = cell_col(lk_a_ff);
      rb = cell_row(lk_b_ff);
      cb = cell_col(lk_b_ff);
      ra_n = ra;
      rb_n = rb;
      ca_n = ca;
      cb_n = cb;
      if (ra == rb) begin
         ca_n = step_rc(ca, decrypt_mode);
         cb_n = step_rc(cb, decrypt_mode);
      end else if (ca == cb) begin
         ra_n = step_rc(ra, decrypt_mode);
         rb_n = step_rc(rb, decrypt_mode);
      end else begin
         ca_n = cb;
         cb_n = ca;
      end
      pos1 = CELL_IDX_W'(ra_n * SQUARE_SIDE + ca_n);
      pos2 = CELL_IDX_W'(rb_n * SQUARE_SIDE + cb_n);
      p1 = cells[pos1];
      p2 = cells[pos2];
      pair_bad = (lk_a_ff == CELL_MISSING) || (lk_b_ff == CELL_MISSING)
                 || (lk_a_ff == lk_b_ff);
   end

   // build the result list of one command
   always_comb begin
      n = '0;
      pend_in = pend_ff;
      held_in = held_ff;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         ent_letter[k] = '0;
         ent_bad[k] = 1'b0;
      end
      if (lk_has_pair_ff) begin
         if (pair_bad) begin
            if (pend_in) begin
               ent_letter[n[SLOT_W-1:0]] = held_in;
               n = n + COUNT_W'(1);
               ent_letter[n[SLOT_W-1:0]] = LETTER_X;
               n = n + COUNT_W'(1);
               pend_in = 1'b0;
            end
            ent_bad[n[SLOT_W-1:0]] = 1'b1;
            n = n + COUNT_W'(1);
         end else begin
            if (pend_in) begin
               ent_letter[n[SLOT_W-1:0]] = held_in;
               n = n + COUNT_W'(1);
               // filler dropped when the next pair repeats the letter
               if (p1 != held_in) begin
                  ent_letter[n[SLOT_W-1:0]] = LETTER_X;
                  n = n + COUNT_W'(1);
               end
               pend_in = 1'b0;
            end
            if (decrypt_mode && p2 == LETTER_X && !lk_last_ff) begin
               held_in = p1;
               pend_in = 1'b1;
            end else begin
               ent_letter[n[SLOT_W-1:0]] = p1;
               n = n + COUNT_W'(1);
               ent_letter[n[SLOT_W-1:0]] = p2;
               n = n + COUNT_W'(1);
            end
         end
      end
      // end of message flushes a withheld pair
      if (lk_last_ff) begin
         if (pend_in) begin
            ent_letter[n[SLOT_W-1:0]] = held_in;
            n = n + COUNT_W'(1);
            ent_letter[n[SLOT_W-1:0]] = LETTER_X;
            n = n + COUNT_W'(1);
         end
         pend_in = 1'b0;
         held_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff <= 1'b0;
         list_busy_ff <= 1'b0;
         list_idx_ff <= '0;
         list_cnt_ff <= '0;
         pend_ff <= 1'b0;
         held_ff <= '0;
      end else begin
         lk_valid_ff <= lk_valid_in;
         if (lk_advance) begin
            pend_ff <= pend_in;
            held_ff <= held_in;
            list_busy_ff <= (n != '0);
            list_cnt_ff <= n;
            list_idx_ff <= '0;
         end else if (list_done) begin
            list_busy_ff <= 1'b0;
         end else if (list_busy_ff && rsp.ready) begin
            list_idx_ff <= list_idx_ff + SLOT_W'(1);
         end
      end
   end

   // list payload
   always_ff @(posedge clock) begin
      if (lk_advance) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            list_letter_ff[k] <= ent_letter[k];
            list_bad_ff[k] <= ent_bad[k];
         end
      end
   end

   assign rsp.valid = list_busy_ff;
   assign rsp.letter_out = list_letter_ff[list_idx_ff];
   assign rsp.bad_input = list_bad_ff[list_idx_ff];
   assign rsp.run_last = ({1'b0, list_idx_ff} == list_cnt_ff - COUNT_W'(1));

   // checks
   a_idx_in_list: assert property (@(posedge clock) disable iff (reset)
      list_busy_ff |-> ({1'b0, list_idx_ff} < list_cnt_ff))
      else $error("result index beyond list");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.bad_input) |-> (rsp.letter_out == '0))
      else $error("error result carries a letter");

   a_list_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.run_last) |=> rsp.valid)
      else $error("result list ended early");

   a_no_load_over_busy: assert property (@(posedge clock) disable iff (reset)
      (list_busy_ff && !rsp.ready) |=> (list_busy_ff && $stable(list_idx_ff)))
      else $error("stalled result list changed");

endmodule

>>> sv/playfair_digram_cipher_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// playfair_digram_cipher_unit
// Digram cipher over a configured 5x5 key square.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one letter word (a=0..z=25) plus an end-of-message flag.
//   rsp_chan carries produced letters; run_last marks the final word caused
//   by one input word, bad_input marks an error word (letter 0).
//   csr_* writes decrypt mode and the square cells; user writes only while idle, not enforced.
// Path: a completing letter's first result passes the queue entry, the lookup
//   register and the result list register before it is valid.
// Throughput: a letter can be accepted every cycle while the command queue
//   has room; results leave at one word per cycle from the result list while
//   rsp ready is high, and a pair that flushes a withheld letter yields up to
//   four words per two letters.
// Reset: synchronous; clears pairing and withheld state, the queue, the
//   result list and all configuration registers.
// Stall: while rsp ready is low the current word holds; the queue keeps
//   taking letters until it fills, then req ready drops.
// ---------------------------------------------------------------------------
module playfair_digram_cipher_unit #(
   parameter int QUEUE_DEPTH = pfc_pkg::PFC_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   pfc_req_if.sink req_chan,
   pfc_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [pfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pfc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfc_pkg::*;

   logic decrypt_ff;
   logic [CSR_DATA_W-1:0] cells_low_ff, cells_mid_ff;
   logic [LETTER_W-1:0] cell_last_ff;
   cells_type cells;

   logic push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff <= 1'b0;
         cells_low_ff <= '0;
         cells_mid_ff <= '0;
         cell_last_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECRYPT_MODE: decrypt_ff <= csr_wdata[0];
            CSR_CELLS_LOW: cells_low_ff <= csr_wdata;
            CSR_CELLS_MID: cells_mid_ff <= csr_wdata;
            CSR_CELL_LAST: cell_last_ff <= csr_wdata[LETTER_W-1:0];
            default: decrypt_ff <= decrypt_ff;
         endcase
      end
   end

   // unpack the square
   always_comb begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (i < LOW_CELLS) cells[i] = cells_low_ff[LETTER_W*i +: LETTER_W];
         else if (i < LOW_CELLS + MID_CELLS)
            cells[i] = cells_mid_ff[LETTER_W*(i-LOW_CELLS) +: LETTER_W];
         else cells[i] = cell_last_ff;
      end
   end

   pfc_front u_front (
      .clock(clock),
      .reset(reset),
      .decrypt_mode(decrypt_ff),
      .req(req_chan),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd)
   );

   pfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd)
   );

   pfc_back u_back (
      .clock(clock),
      .reset(reset),
      .decrypt_mode(decrypt_ff),
      .cells(cells),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd),
      .rsp(rsp_chan)
   );

endmodule
